// File: sv/kwm_pkg.sv
package kwm_pkg;

  // Number of merged sequences and the queue depth of each.
  localparam int NUM_LISTS  = 8;
  localparam int LIST_DEPTH = 64;

  // Derived widths.
  localparam int LIST_W = $clog2(NUM_LISTS);
  localparam int POS_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W  = POS_W + 1;
  localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // Fixed field widths of the stream words.
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 3;
  localparam int STATUS_W = 2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_PUSH_OK    = 2'd0,
    ST_PUSH_FULL  = 2'd1,
    ST_POP_DATA   = 2'd2,
    ST_POP_EMPTY  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_SCAN_TAIL,
    S_POP,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic push_exec;
    logic scan_step;
    logic pop_exec;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/kwm_ram.sv
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, write or registered read at one address per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/kwm_ctrl.sv
module kwm_ctrl import kwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_pop_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = in_pop_i ? S_SCAN : S_PUSH;
        end
      end
      S_PUSH:      state_d = S_EMIT;
      S_SCAN: begin
        if (status_i.scan_last) begin
          state_d = S_SCAN_TAIL;
        end
      end
      S_SCAN_TAIL: state_d = S_POP;
      S_POP:       state_d = S_EMIT;
      S_EMIT: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_PUSH:      cmd_o.push_exec = 1'b1;
      S_SCAN:      cmd_o.scan_step = 1'b1;
      S_SCAN_TAIL: cmd_o          = '0;
      S_POP:       cmd_o.pop_exec  = 1'b1;
      S_EMIT:      cmd_o.emit      = status_i.out_free;
      default:     cmd_o          = '0;
    endcase
  end

endmodule

// File: sv/kwm_dp.sv
module kwm_dp import kwm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic [INDEX_W-1:0]  in_index_i,
  input  logic [VALUE_W-1:0]  in_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [VALUE_W-1:0]  out_value_o,
  output logic [INDEX_W-1:0]  out_list_o
);

  // Per-queue head position and fill count.
  logic [POS_W-1:0]   rp_q [NUM_LISTS];
  logic [CNT_W-1:0]   fc_q [NUM_LISTS];

  // Latched input word.
  logic [INDEX_W-1:0] lane_q;
  logic [VALUE_W-1:0] value_q;

  // Scan state.
  logic [LIST_W-1:0]  scan_q;
  logic               cand_pend_q;
  logic               cand_valid_q;
  logic [LIST_W-1:0]  cand_list_q;
  logic               found_q;
  logic [LIST_W-1:0]  best_q;
  logic [VALUE_W-1:0] best_val_q;

  // Result and output registers.
  logic [STATUS_W-1:0] res_status_q;
  logic [VALUE_W-1:0]  res_value_q;
  logic [INDEX_W-1:0]  res_list_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [VALUE_W-1:0]  out_value_q;
  logic [INDEX_W-1:0]  out_list_q;

  // Shared selection and memory signals.
  logic [LIST_W-1:0]  lane_idx;
  logic [LIST_W-1:0]  sel_idx;
  logic [POS_W-1:0]   sel_rp;
  logic [CNT_W-1:0]   sel_fc;
  logic               lane_ok;
  logic               push_ok;
  logic [SUM_W-1:0]   tail_sum;
  logic [POS_W-1:0]   tail_slot;
  logic [POS_W-1:0]   head_next;
  logic [POS_W-1:0]   mem_slot;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [VALUE_W-1:0] mem_rdata;
  logic               take_cand;

  // One queue is selected at a time: push lane, scanned queue or pop winner.
  always_comb begin
    lane_idx = LIST_W'(lane_q);
    lane_ok  = 32'(lane_q) < NUM_LISTS;
    if (cmd_i.push_exec) begin
      sel_idx = lane_idx;
    end else if (cmd_i.pop_exec) begin
      sel_idx = best_q;
    end else begin
      sel_idx = scan_q;
    end
    sel_rp  = rp_q[sel_idx];
    sel_fc  = fc_q[sel_idx];
    push_ok = lane_ok && (sel_fc != CNT_W'(LIST_DEPTH));
  end

  // Tail and next head slots, wrapped at the queue depth.
  always_comb begin
    tail_sum = SUM_W'(sel_rp) + SUM_W'(sel_fc);
    if (tail_sum >= SUM_W'(LIST_DEPTH)) begin
      tail_slot = POS_W'(tail_sum - SUM_W'(LIST_DEPTH));
    end else begin
      tail_slot = POS_W'(tail_sum);
    end
    if (sel_rp == POS_W'(LIST_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = sel_rp + POS_W'(1);
    end
  end

  // Memory address: queue base plus slot.
  always_comb begin
    mem_slot = cmd_i.push_exec ? tail_slot : sel_rp;
    mem_addr = ADDR_W'(sel_idx) * ADDR_W'(LIST_DEPTH) + ADDR_W'(mem_slot);
    mem_we   = cmd_i.push_exec && push_ok;
  end

  kwm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (value_q),
    .rdata_o (mem_rdata)
  );

  // A candidate head replaces the best one only when strictly smaller.
  assign take_cand = cand_pend_q && cand_valid_q &&
                     (!found_q || ($signed(mem_rdata) < $signed(best_val_q)));

  // Queue positions and fill counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        rp_q[i] <= '0;
        fc_q[i] <= '0;
      end
    end else if (cmd_i.push_exec && push_ok) begin
      fc_q[sel_idx] <= sel_fc + CNT_W'(1);
    end else if (cmd_i.pop_exec && found_q) begin
      rp_q[sel_idx] <= head_next;
      fc_q[sel_idx] <= sel_fc - CNT_W'(1);
    end
  end

  // Scan control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      cand_pend_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      cand_pend_q <= cmd_i.scan_step;
      if (cmd_i.load_in) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          scan_q <= scan_q + LIST_W'(1);
        end
        if (take_cand) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // Input word, scan candidate and best head payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      lane_q  <= in_index_i;
      value_q <= in_value_i;
    end
    if (cmd_i.scan_step) begin
      cand_valid_q <= (sel_fc != '0);
      cand_list_q  <= scan_q;
    end
    if (take_cand) begin
      best_q     <= cand_list_q;
      best_val_q <= mem_rdata;
    end
  end

  // Result of the current item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_exec) begin
      res_status_q <= push_ok ? ST_PUSH_OK : ST_PUSH_FULL;
      res_value_q  <= '0;
      res_list_q   <= '0;
    end else if (cmd_i.pop_exec) begin
      if (found_q) begin
        res_status_q <= ST_POP_DATA;
        res_value_q  <= best_val_q;
        res_list_q   <= INDEX_W'(best_q);
      end else begin
        res_status_q <= ST_POP_EMPTY;
        res_value_q  <= '0;
        res_list_q   <= '0;
      end
    end
  end

  // Output register: holds one word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_list_q   <= res_list_q;
    end
  end

  assign status_o.scan_last = (scan_q == LIST_W'(NUM_LISTS - 1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_list_o   = out_list_q;

endmodule

// File: sv/k_way_sorted_merge.sv
// K-way sorted merge over eight queues of 64 signed 32-bit words each, held in
// one single-port RAM. A push word appends a value to the queue given by its
// index and answers with status 0, or 1 when that queue is full and the value
// is dropped. A pop word returns the smallest head value of all non-empty
// queues with its queue number (status 2, lowest queue wins on a tie), or
// status 3 when every queue is empty. Items are handled one at a time: a push
// passes through the states PUSH and EMIT before the next input word is
// accepted; a pop passes through SCAN, SCAN_TAIL, POP and EMIT, reading the
// heads one queue per cycle through the RAM's single port and comparing them
// as they arrive. The result sits in an output register, so the next input
// word is accepted while it waits for the sink; a later result is held back,
// and the input with it, for as long as that register is still full.
// No clearing pass is needed after reset.
module k_way_sorted_merge import kwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] item_value
  input  logic [3:0]  s_axis_tuser,   // [0] command, [3:1] list_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] out_value, [34:32] source_list, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  ctrl_cmd_t          cmd;
  dp_status_t         dp_status;
  logic [VALUE_W-1:0] out_value;
  logic [INDEX_W-1:0] out_list;

  kwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_pop_i   (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  kwm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .in_index_i   (s_axis_tuser[3:1]),
    .in_value_i   (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_value_o  (out_value),
    .out_list_o   (out_list)
  );

  // Pack the result word.
  assign m_axis_tdata = {5'd0, out_list, out_value};

endmodule
